### rtl/core/task_to_processor_dispatcher_defines.svh
// ----------------------------------------------------------------------------
// Task dispatcher assertion macros
// Concurrent check macros; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef TASK_TO_PROCESSOR_DISPATCHER_DEFINES_SVH
`define TASK_TO_PROCESSOR_DISPATCHER_DEFINES_SVH

`ifndef SYNTH
`define TTPD_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ttpd check failed");
`define TTPD_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ttpd check failed");
`else
`define TTPD_ASSERT_IMP(lbl, a, b)
`define TTPD_ASSERT_NXT(lbl, a, b)
`endif

`endif

### rtl/core/ttpd_pkg.sv
// ----------------------------------------------------------------------------
// ttpd_pkg
// Shared constants, codes and controller/datapath types of the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ttpd_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int PROCESSORS = 4;
  localparam int MAX_STARTS = 4;

  localparam int SLOT_W  = $clog2(TASK_SLOTS);
  localparam int CNT_W   = $clog2(TASK_SLOTS + 1);
  localparam int PROC_W  = 2;
  localparam int ID_W    = 7;
  localparam int CODE_W  = 3;
  localparam int OP_W    = 2;
  localparam int START_W = $clog2(MAX_STARTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT,
    OP_FINISH,
    OP_PROMOTE,
    OP_LOOKUP
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    RC_STARTED,
    RC_QUEUED,
    RC_FULL,
    RC_FREED,
    RC_IDLE_PROC,
    RC_RUNNING,
    RC_NOT_RUNNING,
    RC_NONE_PROMOTED
  } code_t;

  typedef enum logic [1:0] {
    TS_UNUSED,
    TS_WAITING,
    TS_RUNNING,
    TS_FINISHED
  } tstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUBMIT,
    S_FINISH,
    S_LOOKUP,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd_query;
    logic scan_clr;
    logic scan_adv;
    logic do_submit;
    logic do_finish;
    logic do_lookup;
    logic do_start;
    logic do_flush;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic out_free;
    logic pend_valid;
    logic scan_in_range;
    logic scan_waiting;
    logic proc_free;
    logic start_max;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/ttpd_in_if.sv
// ----------------------------------------------------------------------------
// ttpd_in_if
// Event channel: opcode, processor and task id with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttpd_in_if import ttpd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PROC_W-1:0] processor;
  logic [ID_W-1:0]   task_id;

  modport source (output valid, output opcode, output processor, output task_id,
                  input ready);
  modport sink   (input valid, input opcode, input processor, input task_id,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/ttpd_out_if.sv
// ----------------------------------------------------------------------------
// ttpd_out_if
// Result channel: code, task id, processor, all_done and last with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttpd_out_if import ttpd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  logic [ID_W-1:0]   task_id_out;
  logic [PROC_W-1:0] processor_out;
  logic              all_done;
  logic              last;

  modport source (output valid, output code, output task_id_out, output processor_out,
                  output all_done, output last, input ready);
  modport sink   (input valid, input code, input task_id_out, input processor_out,
                  input all_done, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/ttpd_ctrl.sv
// ----------------------------------------------------------------------------
// ttpd_ctrl
// Sequencer: takes an event, runs its operation or the promote scan, and
// paces result beats against the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpd_ctrl import ttpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   scan_go;

  assign scan_go = sts.scan_in_range && sts.proc_free && !sts.start_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (sts.in_op)
            OP_SUBMIT:  state_next = S_SUBMIT;
            OP_FINISH:  state_next = S_FINISH;
            OP_PROMOTE: state_next = S_SCAN;
            OP_LOOKUP:  state_next = S_LOOKUP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SUBMIT, S_FINISH, S_LOOKUP, S_FLUSH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (!scan_go) state_next = S_FLUSH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_in  = in_valid;
        cmd.scan_clr = 1'b1;
        cmd.rd_query = (sts.in_op == OP_LOOKUP);
      end
      S_SUBMIT: cmd.do_submit = sts.out_free;
      S_FINISH: cmd.do_finish = sts.out_free;
      S_LOOKUP: begin
        cmd.rd_query  = 1'b1;
        cmd.do_lookup = sts.out_free;
      end
      S_SCAN: begin
        if (scan_go) begin
          if (sts.scan_waiting) begin
            if (!sts.pend_valid || sts.out_free) begin
              cmd.do_start = 1'b1;
              cmd.scan_adv = 1'b1;
            end
          end else begin
            cmd.scan_adv = 1'b1;
          end
        end
      end
      S_FLUSH: cmd.do_flush = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ttpd_datapath.sv
// ----------------------------------------------------------------------------
// ttpd_datapath
// Task table memories, processor map, counters, promote scan pointer,
// held promote result and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpd_datapath import ttpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [PROC_W-1:0] in_processor,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_code,
  output logic [ID_W-1:0]   out_task_id,
  output logic [PROC_W-1:0] out_processor,
  output logic              out_all_done,
  output logic              out_last
);

  logic [PROC_W-1:0] proc_q;
  logic [ID_W-1:0]   qid_q;

  tstat_t            status_mem [TASK_SLOTS];
  logic [PROC_W-1:0] tproc_mem  [TASK_SLOTS];
  tstat_t            rd_status;
  logic [PROC_W-1:0] rd_tproc;

  logic [CNT_W-1:0]    tasks_used;
  logic [CNT_W-1:0]    fin_cnt;
  logic [PROCESSORS-1:0] busy;
  logic [SLOT_W-1:0]   run_slot [PROCESSORS];
  logic [CNT_W-1:0]    scan_ptr;
  logic [CNT_W-1:0]    scan_ptr_next;
  logic [START_W-1:0]  start_cnt;
  logic                pend_valid;
  logic [ID_W-1:0]     pend_id;
  logic [PROC_W-1:0]   pend_proc;

  logic              free_found;
  logic [PROC_W-1:0] free_idx;
  logic              full;
  logic [SLOT_W-1:0] submit_slot;
  logic [SLOT_W-1:0] fin_slot;
  logic [SLOT_W-1:0] scan_slot;
  logic [ID_W-1:0]   query_id;
  logic [SLOT_W-1:0] rd_addr;
  logic              lookup_hit;

  logic              wr_en;
  logic              wr_tproc_en;
  logic [SLOT_W-1:0] wr_addr;
  tstat_t            wr_status;
  logic              used_inc;
  logic              fin_inc;
  logic              busy_set;
  logic              busy_clr;
  logic              pend_load;
  logic              emit;
  code_t             e_code;
  logic [ID_W-1:0]   e_id;
  logic [PROC_W-1:0] e_proc;
  logic              e_last;
  logic [CNT_W-1:0]  used_next;
  logic [CNT_W-1:0]  fin_next;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PROCESSORS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = PROC_W'(i);
      end
    end
  end

  assign full          = (tasks_used == CNT_W'(TASK_SLOTS));
  assign submit_slot   = tasks_used[SLOT_W-1:0];
  assign fin_slot      = run_slot[proc_q];
  assign scan_slot     = scan_ptr[SLOT_W-1:0];
  assign scan_ptr_next = cmd.scan_clr ? '0 :
                         cmd.scan_adv ? scan_ptr + CNT_W'(1) : scan_ptr;
  assign query_id      = cmd.load_in ? in_task_id : qid_q;
  assign rd_addr       = cmd.rd_query ? SLOT_W'(query_id - ID_W'(1))
                                      : scan_ptr_next[SLOT_W-1:0];
  assign lookup_hit    = (qid_q != '0) && (qid_q <= ID_W'(tasks_used)) &&
                         (rd_status == TS_RUNNING);

  always_comb begin
    wr_en       = 1'b0;
    wr_tproc_en = 1'b0;
    wr_addr     = submit_slot;
    wr_status   = TS_RUNNING;
    used_inc    = 1'b0;
    fin_inc     = 1'b0;
    busy_set    = 1'b0;
    busy_clr    = 1'b0;
    pend_load   = 1'b0;
    emit        = 1'b0;
    e_code      = RC_STARTED;
    e_id        = '0;
    e_proc      = '0;
    e_last      = 1'b1;
    priority if (cmd.do_submit) begin
      emit = 1'b1;
      if (full) begin
        e_code = RC_FULL;
      end else begin
        used_inc = 1'b1;
        wr_en    = 1'b1;
        e_id     = ID_W'(submit_slot) + ID_W'(1);
        if (free_found) begin
          wr_tproc_en = 1'b1;
          busy_set    = 1'b1;
          e_proc      = free_idx;
        end else begin
          wr_status = TS_WAITING;
          e_code    = RC_QUEUED;
        end
      end
    end else if (cmd.do_finish) begin
      emit   = 1'b1;
      e_proc = proc_q;
      if (!busy[proc_q]) begin
        e_code = RC_IDLE_PROC;
      end else begin
        wr_en     = 1'b1;
        wr_addr   = fin_slot;
        wr_status = TS_FINISHED;
        busy_clr  = 1'b1;
        fin_inc   = 1'b1;
        e_code    = RC_FREED;
        e_id      = ID_W'(fin_slot) + ID_W'(1);
      end
    end else if (cmd.do_lookup) begin
      emit = 1'b1;
      e_id = qid_q;
      if (lookup_hit) begin
        e_code = RC_RUNNING;
        e_proc = rd_tproc;
      end else begin
        e_code = RC_NOT_RUNNING;
      end
    end else if (cmd.do_start) begin
      wr_en       = 1'b1;
      wr_tproc_en = 1'b1;
      wr_addr     = scan_slot;
      busy_set    = 1'b1;
      pend_load   = 1'b1;
      emit        = pend_valid;
      e_id        = pend_id;
      e_proc      = pend_proc;
      e_last      = 1'b0;
    end else if (cmd.do_flush) begin
      emit = 1'b1;
      if (pend_valid) begin
        e_id   = pend_id;
        e_proc = pend_proc;
      end else begin
        e_code = RC_NONE_PROMOTED;
      end
    end
  end

  assign used_next = tasks_used + CNT_W'(used_inc);
  assign fin_next  = fin_cnt + CNT_W'(fin_inc);

  always_ff @(posedge clk) begin
    if (wr_en) status_mem[wr_addr] <= wr_status;
    if (wr_tproc_en) tproc_mem[wr_addr] <= free_idx;
    rd_status <= status_mem[rd_addr];
    rd_tproc  <= tproc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      proc_q <= in_processor;
      qid_q  <= in_task_id;
    end
    if (busy_set) run_slot[free_idx] <= wr_addr;
    if (pend_load) begin
      pend_id   <= ID_W'(scan_slot) + ID_W'(1);
      pend_proc <= free_idx;
    end
    if (emit) begin
      out_code      <= e_code;
      out_task_id   <= e_id;
      out_processor <= e_proc;
      out_all_done  <= (fin_next == used_next);
      out_last      <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tasks_used <= '0;
      fin_cnt    <= '0;
      busy       <= '0;
      scan_ptr   <= '0;
      start_cnt  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      tasks_used <= used_next;
      fin_cnt    <= fin_next;
      scan_ptr   <= scan_ptr_next;
      if (busy_set) busy[free_idx] <= 1'b1;
      if (busy_clr) busy[proc_q] <= 1'b0;
      if (cmd.load_in) begin
        start_cnt  <= '0;
        pend_valid <= 1'b0;
      end else if (pend_load) begin
        start_cnt  <= start_cnt + START_W'(1);
        pend_valid <= 1'b1;
      end else if (cmd.do_flush) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.in_op         = op_t'(in_opcode);
  assign sts.out_free      = !out_valid || out_ready;
  assign sts.pend_valid    = pend_valid;
  assign sts.scan_in_range = (scan_ptr < tasks_used);
  assign sts.scan_waiting  = (rd_status == TS_WAITING);
  assign sts.proc_free     = free_found;
  assign sts.start_max     = (start_cnt == START_W'(MAX_STARTS));

endmodule

`default_nettype wire

### rtl/core/task_to_processor_dispatcher.sv
// ----------------------------------------------------------------------------
// task_to_processor_dispatcher
// Dispatches submitted tasks onto a small processor pool, frees processors
// on finish, promotes waiting tasks and looks up running tasks.
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------
//   req     | in  | opcode, processor, task_id
//   rsp     | out | code, task_id_out, processor_out, all_done, last
//
// Submit, finish and lookup load the result register from their operation
// state once that register is free. Promote walks the task table one slot per
// cycle from slot 0, holding on a waiting slot while the rsp side stalls.
// Synchronous reset; the table needs no clearing pass (fill count).
// A new event is taken once the previous one has loaded its last beat,
// while that beat may still wait in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_to_processor_dispatcher_defines.svh"

module task_to_processor_dispatcher import ttpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  ttpd_in_if.sink    req,
  ttpd_out_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  ttpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttpd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (req.opcode),
    .in_processor  (req.processor),
    .in_task_id    (req.task_id),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_code      (rsp.code),
    .out_task_id   (rsp.task_id_out),
    .out_processor (rsp.processor_out),
    .out_all_done  (rsp.all_done),
    .out_last      (rsp.last)
  );

  `TTPD_ASSERT_IMP(a_emit_room, (cmd.do_submit || cmd.do_finish || cmd.do_lookup || cmd.do_flush || (cmd.do_start && sts.pend_valid)), sts.out_free)
  `TTPD_ASSERT_IMP(a_start_cap, cmd.do_start, (!sts.start_max && sts.proc_free))
  `TTPD_ASSERT_NXT(a_busy_after_accept, (req.valid && req.ready), !req.ready)

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for task_to_processor_dispatcher. A short table of
// directed events (reset state, id extremes, queueing, promote, idle finish)
// runs first, then random events biased toward busy processors and live ids.
// Every accepted event is run through an in-bench dispatcher model, and each
// result beat is compared field by field in order. Bursty sender, stalling
// receiver with long hold-offs, idle-cycle watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttpd_pkg::*;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_EVENTS = 475;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 120;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    code_t             code;
    logic [ID_W-1:0]   id;
    logic [PROC_W-1:0] cpu;
    logic              done;
    logic              last;
  } beat_t;

  typedef struct packed {
    op_t               op;
    logic [PROC_W-1:0] cpu;
    logic [ID_W-1:0]   id;
    logic              typed;
    beat_t             want;
  } event_t;

  localparam beat_t NO_BEAT = '0;

  logic clk;
  logic rst;

  ttpd_in_if  req_bus ();
  ttpd_out_if rsp_bus ();

  task_to_processor_dispatcher dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // dispatcher model state
  tstat_t            slot_state [TASK_SLOTS];
  logic [PROC_W-1:0] slot_cpu   [TASK_SLOTS];
  logic              cpu_busy   [PROCESSORS];
  int                slots_taken;

  beat_t fresh [MAX_STARTS];
  int    fresh_n;

  beat_t  expected_beats [$];
  event_t offered [$];

  int mismatches;
  int events_in;
  int beats_seen;
  int code_hits [8];
  int quiet_cycles;
  int burst_left;

  initial begin
    for (int s = 0; s < TASK_SLOTS; s++) begin
      slot_state[s] = TS_UNUSED;
      slot_cpu[s]   = '0;
    end
    for (int p = 0; p < PROCESSORS; p++) cpu_busy[p] = 1'b0;
    for (int c = 0; c < 8; c++) code_hits[c] = 0;
    slots_taken = 0;
    mismatches  = 0;
    events_in   = 0;
    beats_seen  = 0;
  end

  function automatic int lowest_idle_cpu();
    for (int p = 0; p < PROCESSORS; p++)
      if (!cpu_busy[p]) return p;
    return -1;
  endfunction

  function automatic logic every_task_done();
    for (int s = 0; s < slots_taken; s++)
      if (slot_state[s] != TS_FINISHED) return 1'b0;
    return 1'b1;
  endfunction

  task automatic log_beat(input code_t c, input int id, input int cpu);
    beat_t b;
    b.code = c;
    b.id   = ID_W'(id);
    b.cpu  = PROC_W'(cpu);
    b.done = every_task_done();
    b.last = 1'b0;
    fresh[fresh_n] = b;
    fresh_n++;
  endtask

  task automatic start_on(input int s, input int p);
    slot_state[s] = TS_RUNNING;
    slot_cpu[s]   = PROC_W'(p);
    cpu_busy[p]   = 1'b1;
    log_beat(RC_STARTED, s + 1, p);
  endtask

  task automatic dispatch_event(input op_t op, input logic [PROC_W-1:0] cpu,
                                input logic [ID_W-1:0] qid);
    int s;
    int p;
    int id;
    int q;
    logic stop;
    fresh_n = 0;
    case (op)
      OP_SUBMIT: begin
        if (slots_taken >= TASK_SLOTS) begin
          log_beat(RC_FULL, 0, 0);
        end else begin
          s = slots_taken;
          slots_taken++;
          p = lowest_idle_cpu();
          if (p >= 0) begin
            start_on(s, p);
          end else begin
            slot_state[s] = TS_WAITING;
            log_beat(RC_QUEUED, s + 1, 0);
          end
        end
      end
      OP_FINISH: begin
        if (!cpu_busy[cpu]) begin
          log_beat(RC_IDLE_PROC, 0, cpu);
        end else begin
          id = 0;
          for (s = 0; s < slots_taken; s++) begin
            if (id == 0 && slot_state[s] == TS_RUNNING && slot_cpu[s] == cpu) begin
              slot_state[s] = TS_FINISHED;
              id = s + 1;
            end
          end
          cpu_busy[cpu] = 1'b0;
          log_beat(RC_FREED, id, cpu);
        end
      end
      OP_PROMOTE: begin
        stop = 1'b0;
        for (s = 0; s < slots_taken && fresh_n < MAX_STARTS && !stop; s++) begin
          if (slot_state[s] == TS_WAITING) begin
            p = lowest_idle_cpu();
            if (p < 0) stop = 1'b1;
            else start_on(s, p);
          end
        end
        if (fresh_n == 0) log_beat(RC_NONE_PROMOTED, 0, 0);
      end
      default: begin
        q = int'(qid);
        if (q >= 1 && q <= slots_taken && slot_state[q-1] == TS_RUNNING)
          log_beat(RC_RUNNING, q, slot_cpu[q-1]);
        else
          log_beat(RC_NOT_RUNNING, q, 0);
      end
    endcase
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] beat %0d: %s", $time, beats_seen, what);
  endtask

  // event accept: run the model, queue what should come back
  always @(posedge clk) begin : req_accept
    event_t ev;
    beat_t  b;
    if (!rst && req_bus.valid && req_bus.ready) begin
      ev = offered.pop_front();
      dispatch_event(op_t'(req_bus.opcode), req_bus.processor, req_bus.task_id);
      if (ev.typed) begin
        b = ev.want;
        b.last = 1'b1;
        expected_beats.push_back(b);
      end else begin
        for (int i = 0; i < fresh_n; i++) begin
          b = fresh[i];
          b.last = (i == fresh_n - 1);
          expected_beats.push_back(b);
        end
      end
      events_in++;
    end
  end

  always @(posedge clk) begin : rsp_check
    beat_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      beats_seen++;
      code_hits[rsp_bus.code]++;
      if (expected_beats.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        if (rsp_bus.code !== want.code)
          note_mismatch($sformatf("code %0d, want %0d", rsp_bus.code, want.code));
        if (rsp_bus.task_id_out !== want.id)
          note_mismatch($sformatf("task_id_out %0d, want %0d", rsp_bus.task_id_out, want.id));
        if (rsp_bus.processor_out !== want.cpu)
          note_mismatch($sformatf("processor_out %0d, want %0d",
                                  rsp_bus.processor_out, want.cpu));
        if (rsp_bus.all_done !== want.done)
          note_mismatch($sformatf("all_done %0b, want %0b", rsp_bus.all_done, want.done));
        if (rsp_bus.last !== want.last)
          note_mismatch($sformatf("last %0b, want %0b", rsp_bus.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // directed events; want is filled only where it is obvious
  event_t script [DIRECTED_ROWS] = '{
    '{OP_LOOKUP,  2'd0, 7'd0,   1'b1, '{RC_NOT_RUNNING,   7'd0,   2'd0, 1'b1, 1'b1}},
    '{OP_PROMOTE, 2'd0, 7'd0,   1'b1, '{RC_NONE_PROMOTED, 7'd0,   2'd0, 1'b1, 1'b1}},
    '{OP_FINISH,  2'd3, 7'd0,   1'b1, '{RC_IDLE_PROC,     7'd0,   2'd3, 1'b1, 1'b1}},
    '{OP_LOOKUP,  2'd0, 7'd127, 1'b1, '{RC_NOT_RUNNING,   7'd127, 2'd0, 1'b1, 1'b1}},
    '{OP_SUBMIT,  2'd3, 7'd127, 1'b1, '{RC_STARTED,       7'd1,   2'd0, 1'b0, 1'b1}},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_SUBMIT,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_LOOKUP,  2'd0, 7'd1,   1'b0, NO_BEAT},
    '{OP_LOOKUP,  2'd0, 7'd6,   1'b0, NO_BEAT},
    '{OP_FINISH,  2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_FINISH,  2'd1, 7'd0,   1'b0, NO_BEAT},
    '{OP_FINISH,  2'd2, 7'd0,   1'b0, NO_BEAT},
    '{OP_FINISH,  2'd3, 7'd0,   1'b0, NO_BEAT},
    '{OP_PROMOTE, 2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_PROMOTE, 2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_FINISH,  2'd2, 7'd0,   1'b0, NO_BEAT},
    '{OP_PROMOTE, 2'd0, 7'd0,   1'b0, NO_BEAT},
    '{OP_LOOKUP,  2'd0, 7'd64,  1'b1, '{RC_NOT_RUNNING,   7'd64,  2'd0, 1'b0, 1'b1}},
    '{OP_LOOKUP,  2'd0, 7'd65,  1'b1, '{RC_NOT_RUNNING,   7'd65,  2'd0, 1'b0, 1'b1}}
  };

  task automatic pick_event(input logic heavy_submit, output event_t ev);
    int roll;
    int busy_list [$];
    int hi;
    ev = '0;
    ev.cpu = PROC_W'($urandom);
    ev.id  = ID_W'($urandom);
    roll = $urandom_range(99);
    if (heavy_submit ? roll < 50 : roll < 10) begin
      ev.op = OP_SUBMIT;
    end else if (heavy_submit ? roll < 70 : roll < 50) begin
      ev.op = OP_FINISH;
      for (int p = 0; p < PROCESSORS; p++)
        if (cpu_busy[p]) busy_list.push_back(p);
      if (busy_list.size() > 0 && $urandom_range(99) < 85)
        ev.cpu = PROC_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
    end else if (heavy_submit ? roll < 85 : roll < 80) begin
      ev.op = OP_PROMOTE;
    end else begin
      ev.op = OP_LOOKUP;
      hi = slots_taken + 1;
      if ($urandom_range(99) < 75) ev.id = ID_W'($urandom_range(hi, 1));
    end
  endtask

  // one event on the req channel, then the burst/gap bookkeeping
  task automatic offer(input event_t ev);
    int gap;
    req_bus.valid     <= 1'b1;
    req_bus.opcode    <= ev.op;
    req_bus.processor <= ev.cpu;
    req_bus.task_id   <= ev.id;
    offered.push_back(ev);
    do @(posedge clk); while (!req_bus.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : sender
    event_t ev;
    logic   heavy_submit;
    req_bus.valid     = 1'b0;
    req_bus.opcode    = '0;
    req_bus.processor = '0;
    req_bus.task_id   = '0;
    burst_left = $urandom_range(1, 8);
    heavy_submit = 1'b1;
    do @(posedge clk); while (rst);
    for (int i = 0; i < DIRECTED_ROWS; i++) offer(script[i]);
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 40 == 0) heavy_submit = 1'($urandom_range(1));
      pick_event(heavy_submit, ev);
      offer(ev);
    end
    req_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d events (%0d directed), %0d result beats, %0d of %0d slots taken",
             events_in, DIRECTED_ROWS, beats_seen, slots_taken, TASK_SLOTS);
    $display("beats by code: start %0d queue %0d full %0d freed %0d idle %0d run %0d %0d %0d",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3],
             code_hits[4], code_hits[5], code_hits[6], code_hits[7]);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: random stalls, plus two long hold-offs so the dispatcher backs up
  initial begin : receiver
    int holds_done;
    int run;
    int stall;
    rsp_bus.ready = 1'b0;
    holds_done = 0;
    do @(posedge clk); while (rst);
    forever begin
      stall = ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0;
      if ((holds_done == 0 && events_in >= 120) || (holds_done == 1 && events_in >= 380)) begin
        holds_done++;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      run = ($urandom_range(7) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 20);
      rsp_bus.ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

endmodule

`default_nettype wire

### task_to_processor_dispatcher.f
+incdir+rtl/core
rtl/core/ttpd_pkg.sv
rtl/core/ttpd_in_if.sv
rtl/core/ttpd_out_if.sv
rtl/core/ttpd_ctrl.sv
rtl/core/ttpd_datapath.sv
rtl/core/task_to_processor_dispatcher.sv
verif/tb.sv
